### sv/assert_macros.svh
// Assertion macros for the RTL of the steering block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

### sv/lsps_pkg.sv
// Types, constants and helper functions of the line sensor PD steering block.
package lsps_pkg;

	localparam int SensorCount = 7;
	localparam int SampleW     = 10;
	localparam int CfgW        = 10;
	localparam int CfgIdxW     = 3;
	localparam int SumW        = 14;
	localparam int DiffW       = 15;
	localparam int SpeedW      = 25;
	localparam int ScaledW     = 20;

	typedef logic [SampleW-1:0]        sample_t;
	typedef logic [CfgW-1:0]           cfg_val_t;
	typedef logic [CfgIdxW-1:0]        cfg_idx_t;
	typedef logic signed [SumW-1:0]    esum_t;
	typedef logic signed [DiffW-1:0]   ediff_t;
	typedef logic signed [SpeedW-1:0]  speed_t;
	typedef logic [ScaledW-1:0]        scaled_t;
	typedef logic [SensorCount-1:0]    dark_vec_t;

	// Register indexes of the configuration port
	typedef enum logic [CfgIdxW-1:0] {
		CFG_RANGE_LOW    = 3'd0,
		CFG_RANGE_HIGH   = 3'd1,
		CFG_DETECT_LEVEL = 3'd2,
		CFG_BASE_SPEED   = 3'd3,
		CFG_KP_MILLI     = 3'd4,
		CFG_KD_MILLI     = 3'd5
	} cfg_reg_t;

	// Reset values of the configuration registers
	localparam cfg_val_t RangeLowRst    = 10'd300;
	localparam cfg_val_t RangeHighRst   = 10'd880;
	localparam cfg_val_t DetectLevelRst = 10'd70;
	localparam cfg_val_t BaseSpeedRst   = 10'd400;
	localparam cfg_val_t KpMilliRst     = 10'd100;
	localparam cfg_val_t KdMilliRst     = 10'd40;

	// Full scale of a normalised sample
	localparam cfg_val_t NormFull = 10'd1000;

	// Bound on the magnitude of an error sum
	localparam esum_t SumLimit = 14'sd5100;

	// Pattern of dark sensors, sensor one in bit zero
	localparam dark_vec_t HardLeftPat  = 7'b1100000;
	localparam dark_vec_t HardRightPat = 7'b0000011;

	// Steering weight of each sensor, in thousandths
	localparam esum_t SensorWeight [SensorCount] = '{
		14'sd2500, 14'sd1100, 14'sd500, 14'sd0, -14'sd500, -14'sd1100, -14'sd2500
	};

	// Decide whether a sample counts as dark. The normalised value
	// floor((v - lo) * 1000 / (hi - lo)) reaches a level of 1..1000 exactly
	// when (v - lo) * 1000 >= level * (hi - lo), so no divide is needed;
	// thr carries level * (hi - lo).
	function automatic logic sens_dark(
		input sample_t  v,
		input sample_t  lo,
		input logic     ordered,
		input cfg_val_t lvl,
		input scaled_t  thr
	);
		sample_t x;
		scaled_t scaled;
		logic    dark;
		x      = v - lo;
		scaled = ScaledW'(x) * ScaledW'(NormFull);
		if (lvl == '0) begin
			dark = 1'b1;
		end else if (lvl > NormFull) begin
			dark = 1'b0;
		end else if (v <= lo) begin
			dark = 1'b0;
		end else if (!ordered) begin
			dark = 1'b1;
		end else begin
			dark = (scaled >= thr);
		end
		return dark;
	endfunction

endpackage

### sv/lsps_if.sv
// Channel interfaces of the steering block: sample frames, results, configuration.
interface lsps_sample_if;
	logic              valid;
	logic              ready;
	lsps_pkg::sample_t reflect_1;
	lsps_pkg::sample_t reflect_2;
	lsps_pkg::sample_t reflect_3;
	lsps_pkg::sample_t reflect_4;
	lsps_pkg::sample_t reflect_5;
	lsps_pkg::sample_t reflect_6;
	lsps_pkg::sample_t reflect_7;

	modport source (
		output valid, reflect_1, reflect_2, reflect_3, reflect_4, reflect_5,
			reflect_6, reflect_7,
		input  ready
	);
	modport sink (
		input  valid, reflect_1, reflect_2, reflect_3, reflect_4, reflect_5,
			reflect_6, reflect_7,
		output ready
	);
endinterface

interface lsps_result_if;
	logic             valid;
	logic             ready;
	lsps_pkg::speed_t right_wheel_speed;
	lsps_pkg::speed_t left_wheel_speed;
	logic             hard_left;
	logic             hard_right;

	modport source (
		output valid, right_wheel_speed, left_wheel_speed, hard_left, hard_right,
		input  ready
	);
	modport sink (
		input  valid, right_wheel_speed, left_wheel_speed, hard_left, hard_right,
		output ready
	);
endinterface

interface lsps_cfg_if;
	logic               valid;
	logic               ready;
	lsps_pkg::cfg_idx_t index;
	lsps_pkg::cfg_val_t data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

### sv/line_sensor_pd_steering.sv
// Line sensor PD steering: four-stage pipeline from sample frame to wheel speeds.
// A frame passes the input, sum, product and output registers before its result is valid.
// Throughput: one frame per cycle while results are taken; a full stage holds while the next cannot move on.
// Stages: input register, dark detect and error sum, gain products, wheel speed sums.
// Reset clears the pipeline, sets the previous error sum to zero and the
// configuration registers to their default values.
`include "assert_macros.svh"

module line_sensor_pd_steering (
	input  logic                 clk,
	input  logic                 arst_n,
	lsps_sample_if.sink          sample,
	lsps_result_if.source        result,
	lsps_cfg_if.sink             cfg
);

	// Configuration registers
	lsps_pkg::cfg_val_t range_low_q;
	lsps_pkg::cfg_val_t range_high_q;
	lsps_pkg::cfg_val_t detect_level_q;
	lsps_pkg::cfg_val_t base_speed_q;
	lsps_pkg::cfg_val_t kp_milli_q;
	lsps_pkg::cfg_val_t kd_milli_q;

	// Pipeline valids and enables
	logic v_s1, v_s2, v_s3, out_v_q;
	logic en_1, en_2, en_3, en_o;

	// Stage payloads
	lsps_pkg::sample_t   samp_s1 [lsps_pkg::SensorCount];
	lsps_pkg::dark_vec_t dark_s2;
	lsps_pkg::esum_t     sum_s2;
	logic signed [24:0]  p_s3;
	logic signed [25:0]  d_s3;
	logic [19:0]         base_s3;
	logic                hl_s3, hr_s3;
	lsps_pkg::speed_t    right_q, left_q;
	logic                hl_q, hr_q;

	// Error sum of the previous frame
	lsps_pkg::esum_t     prev_q;

	// Combinational signals
	lsps_pkg::scaled_t   thr_c;
	lsps_pkg::sample_t   span_c;
	logic                ordered_c;
	lsps_pkg::dark_vec_t dark_c;
	lsps_pkg::esum_t     sum_c;
	lsps_pkg::ediff_t    diff_c;
	logic signed [24:0]  p_c;
	logic signed [25:0]  d_c;
	logic signed [10:0]  kp_s, kd_s;
	logic signed [25:0]  corr_c, base_c, right_c, left_c;

	// Configuration writes are always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q    <= lsps_pkg::RangeLowRst;
			range_high_q   <= lsps_pkg::RangeHighRst;
			detect_level_q <= lsps_pkg::DetectLevelRst;
			base_speed_q   <= lsps_pkg::BaseSpeedRst;
			kp_milli_q     <= lsps_pkg::KpMilliRst;
			kd_milli_q     <= lsps_pkg::KdMilliRst;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				lsps_pkg::CFG_RANGE_LOW:    range_low_q    <= cfg.data;
				lsps_pkg::CFG_RANGE_HIGH:   range_high_q   <= cfg.data;
				lsps_pkg::CFG_DETECT_LEVEL: detect_level_q <= cfg.data;
				lsps_pkg::CFG_BASE_SPEED:   base_speed_q   <= cfg.data;
				lsps_pkg::CFG_KP_MILLI:     kp_milli_q     <= cfg.data;
				lsps_pkg::CFG_KD_MILLI:     kd_milli_q     <= cfg.data;
				default: ;
			endcase
		end
	end

	// Advance a stage when it is empty or the stage after it moves on
	assign en_o = !out_v_q || result.ready;
	assign en_3 = !v_s3 || en_o;
	assign en_2 = !v_s2 || en_3;
	assign en_1 = !v_s1 || en_2;
	assign sample.ready = en_1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
			prev_q  <= '0;
		end else begin
			if (en_1) v_s1 <= sample.valid;
			if (en_2) v_s2 <= v_s1;
			if (en_3) v_s3 <= v_s2;
			if (en_o) out_v_q <= v_s3;
			// keep the error sum of the frame that just left the sum stage
			if (en_3 && v_s2) prev_q <= sum_s2;
		end
	end

	// Dark detect: one shared threshold product, one compare per sensor
	assign span_c    = range_high_q - range_low_q;
	assign ordered_c = (range_high_q > range_low_q);
	assign thr_c     = lsps_pkg::ScaledW'(detect_level_q) * lsps_pkg::ScaledW'(span_c);

	always_comb begin
		sum_c = '0;
		for (int i = 0; i < lsps_pkg::SensorCount; i++) begin
			dark_c[i] = lsps_pkg::sens_dark(samp_s1[i], range_low_q, ordered_c,
				detect_level_q, thr_c);
			if (dark_c[i]) sum_c = sum_c + lsps_pkg::SensorWeight[i];
		end
	end

	// Gain products on the error sum and its change
	assign kp_s   = $signed({1'b0, kp_milli_q});
	assign kd_s   = $signed({1'b0, kd_milli_q});
	assign diff_c = lsps_pkg::DiffW'(sum_s2) - lsps_pkg::DiffW'(prev_q);
	assign p_c    = kp_s * sum_s2;
	assign d_c    = kd_s * diff_c;

	// Wheel speeds from base and correction
	assign corr_c  = 26'(p_s3) + d_s3;
	assign base_c  = $signed({6'b0, base_s3});
	assign right_c = base_c - corr_c;
	assign left_c  = base_c + corr_c;

	// Payload registers, loaded as their stage advances
	always_ff @(posedge clk) begin
		if (en_1 && sample.valid) begin
			samp_s1[0] <= sample.reflect_1;
			samp_s1[1] <= sample.reflect_2;
			samp_s1[2] <= sample.reflect_3;
			samp_s1[3] <= sample.reflect_4;
			samp_s1[4] <= sample.reflect_5;
			samp_s1[5] <= sample.reflect_6;
			samp_s1[6] <= sample.reflect_7;
		end
		if (en_2 && v_s1) begin
			dark_s2 <= dark_c;
			sum_s2  <= sum_c;
		end
		if (en_3 && v_s2) begin
			p_s3    <= p_c;
			d_s3    <= d_c;
			base_s3 <= 20'(base_speed_q) * 20'(lsps_pkg::NormFull);
			hl_s3   <= (dark_s2 == lsps_pkg::HardLeftPat);
			hr_s3   <= (dark_s2 == lsps_pkg::HardRightPat);
		end
		if (en_o && v_s3) begin
			right_q <= right_c[24:0];
			left_q  <= left_c[24:0];
			hl_q    <= hl_s3;
			hr_q    <= hr_s3;
		end
	end

	assign result.valid             = out_v_q;
	assign result.right_wheel_speed = right_q;
	assign result.left_wheel_speed  = left_q;
	assign result.hard_left         = hl_q;
	assign result.hard_right        = hr_q;

	// Checks
	`ASSERT_CLK(a_accept_fills_s1, clk, arst_n, (sample.valid && sample.ready) |=> v_s1, "accepted beat did not reach the input stage")
	`ASSERT_CLK(a_prev_holds, clk, arst_n, !(en_3 && v_s2) |=> $stable(prev_q), "previous error sum changed without a frame moving on")
	`ASSERT_CLK(a_sum_range, clk, arst_n, v_s2 |-> (sum_s2 <= lsps_pkg::SumLimit && sum_s2 >= -lsps_pkg::SumLimit), "error sum out of range")
	`ASSERT_NEVER(a_flags_excl, clk, arst_n, out_v_q && hl_q && hr_q, "both hard turn flags set")

endmodule
